FILE: hdl/isp_pkg.sv
`default_nettype none

package isp_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 18;
    localparam int PEAK_W     = 25;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int FRAC_SHIFT = 17;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
    localparam int ROM_ROWS   = 4;
    localparam int ROM_COLS   = 12;

    typedef logic signed [COEF_W-1:0] coef_t;

    // Blackman-windowed sinc polyphase rows, each normalized to unity gain, Q1.17
    localparam coef_t COEF_ROM [ROM_ROWS][ROM_COLS] = '{
        '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd131071,
          18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
        '{-18'sd82, 18'sd659, -18'sd2518, 18'sd7273, -18'sd19760, 18'sd117163,
          18'sd36911, -18'sd11861, 18'sd4376, -18'sd1354, 18'sd273, -18'sd8},
        '{-18'sd48, 18'sd616, -18'sd2637, 18'sd8010, -18'sd21510, 18'sd81105,
          18'sd81105, -18'sd21510, 18'sd8010, -18'sd2637, 18'sd616, -18'sd48},
        '{-18'sd8, 18'sd273, -18'sd1354, 18'sd4376, -18'sd11861, 18'sd36911,
          18'sd117163, -18'sd19760, 18'sd7273, -18'sd2518, 18'sd659, -18'sd82}
    };

    // Taps outside the stored table read as zero
    function automatic coef_t coef_at(input int unsigned row, input int unsigned col);
        coef_t c;
        c = '0;
        if (row < ROM_ROWS && col < ROM_COLS)
        begin
            c = COEF_ROM[row][col];
        end
        return c;
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } isp_state_t;

    typedef struct packed {
        logic load;       // shift the new sample into the history
        logic step;       // one multiply-accumulate, rotate the history
        logic first;      // step opens a phase
        logic last;       // step closes a phase
        logic fin;        // step closes the last phase
        logic out_load;   // move the peak into the output register
    } isp_cmd_t;

    typedef struct packed {
        logic done;       // peak of the last phase is settled
    } isp_status_t;

endpackage

`default_nettype wire

FILE: hdl/isp_sample_if.sv
`default_nettype none

interface isp_sample_if;
    import isp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: hdl/isp_peak_if.sv
`default_nettype none

interface isp_peak_if;
    import isp_pkg::*;

    logic              valid;
    logic              ready;
    logic [PEAK_W-1:0] peak;

    modport source (output valid, output peak, input ready);
    modport sink (input valid, input peak, output ready);
endinterface

`default_nettype wire

FILE: hdl/inter_sample_true_peak.sv
// Inter-sample true-peak detector, polyphase oversampling by PHASES.
//
// samples (sink): one signed Q1.23 audio sample per request, valid/ready.
// peaks (source): one unsigned Q2.23 peak per sample, the largest rounded
//   magnitude among the interpolated points between the two center samples
//   of the history (polyphase rows 1 .. PHASES-1, TAPS taps each), saturated.
//
// A single multiply-accumulate unit walks the taps: the history rotates by
// one position per cycle so the multiplier always reads one fixed register.
// Each sample is accepted, multiplied against every tap of each interpolating
// row, drained through the product, sum and compare stages, and its result
// posted. A new sample is taken once the controller is back in idle.
//
// The result sits in an output register; a stalled receiver does not block
// the next sample, only the posting of the one after it. Reset clears the
// history to zero and drops any pending result.

`default_nettype none

module inter_sample_true_peak #(
    parameter int PHASES = 4,
    parameter int TAPS   = 12
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    isp_sample_if.sink   samples,
    isp_peak_if.source   peaks
);
    import isp_pkg::*;

    localparam int PH_W  = $clog2(PHASES);
    localparam int TAP_W = $clog2(TAPS);

    isp_cmd_t          cmd;
    isp_status_t       status;
    logic [PH_W-1:0]   row;
    logic [TAP_W-1:0]  col;
    logic              in_ready;
    logic              out_valid;
    logic [PEAK_W-1:0] peak;

    // Sequence accept, multiply steps, drain and result posting
    isp_ctrl #(
        .PHASES (PHASES),
        .TAPS   (TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (peaks.ready),
        .status    (status),
        .cmd       (cmd),
        .row       (row),
        .col       (col)
    );

    // Hold the history, run the MAC, track the peak
    isp_datapath #(
        .PHASES (PHASES),
        .TAPS   (TAPS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .row    (row),
        .col    (col),
        .sample (samples.sample),
        .status (status),
        .peak   (peak)
    );

    assign samples.ready = in_ready;
    assign peaks.valid   = out_valid;
    assign peaks.peak    = peak;

endmodule

`default_nettype wire

FILE: hdl/isp_ctrl.sv
`default_nettype none

module isp_ctrl #(
    parameter int PHASES = 4,
    parameter int TAPS   = 12
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire isp_pkg::isp_status_t status,
    output isp_pkg::isp_cmd_t         cmd,
    output logic [$clog2(PHASES)-1:0] row,
    output logic [$clog2(TAPS)-1:0]   col
);
    import isp_pkg::*;

    localparam int PH_W  = $clog2(PHASES);
    localparam int TAP_W = $clog2(TAPS);

    isp_state_t       state_reg, state_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        tap_next   = tap_reg;
        in_ready   = 1'b0;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = PH_W'(1);
                    tap_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step  = 1'b1;
                cmd.first = (tap_reg == '0);
                cmd.last  = (tap_reg == TAP_W'(TAPS - 1));
                cmd.fin   = cmd.last && (phase_reg == PH_W'(PHASES - 1));
                if (cmd.last)
                begin
                    tap_next   = '0;
                    phase_next = phase_reg + PH_W'(1);
                    if (cmd.fin)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ready) || cmd.out_load;
    end

    assign out_valid = out_valid_reg;
    assign row       = phase_reg;
    assign col       = tap_reg;

endmodule

`default_nettype wire

FILE: hdl/isp_datapath.sv
`default_nettype none

module isp_datapath #(
    parameter int PHASES = 4,
    parameter int TAPS   = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire isp_pkg::isp_cmd_t             cmd,
    input  wire logic [$clog2(PHASES)-1:0]     row,
    input  wire logic [$clog2(TAPS)-1:0]       col,
    input  wire logic signed [isp_pkg::SAMPLE_W-1:0] sample,
    output isp_pkg::isp_status_t               status,
    output logic [isp_pkg::PEAK_W-1:0]         peak
);
    import isp_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(TAPS);
    localparam int RND_W = ACC_W + 1 - FRAC_SHIFT;
    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

    logic signed [SAMPLE_W-1:0] hist_reg [TAPS];
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       step_d1_reg, first_d1_reg, last_d1_reg, fin_d1_reg;
    logic                       last_d2_reg, fin_d2_reg, done_reg;
    logic [PEAK_W-1:0]          best_reg, peak_reg;
    coef_t                      coef;
    logic [ACC_W-1:0]           mag;
    logic [ACC_W:0]             rnd_sum;
    logic [RND_W-1:0]           rnd;
    logic [PEAK_W-1:0]          sat;

    // History: shift in on load, rotate by one on every step so tap 0 is always the operand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (cmd.load || cmd.step)
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i + 1];
            end
            hist_reg[TAPS - 1] <= cmd.load ? sample : hist_reg[0];
        end
    end

    assign coef      = coef_at(32'(row), 32'(col));
    assign prod_next = coef * hist_reg[0];
    assign acc_next  = (first_d1_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);

    // Magnitude, round half up into Q.23, saturate
    assign mag     = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign rnd_sum = {1'b0, mag} + (ACC_W + 1)'(ROUND_HALF);
    assign rnd     = rnd_sum[ACC_W:FRAC_SHIFT];
    assign sat     = (rnd > RND_W'(PEAK_MAX)) ? PEAK_MAX : rnd[PEAK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_d1_reg  <= 1'b0;
            first_d1_reg <= 1'b0;
            last_d1_reg  <= 1'b0;
            fin_d1_reg   <= 1'b0;
            last_d2_reg  <= 1'b0;
            fin_d2_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            step_d1_reg  <= cmd.step;
            first_d1_reg <= cmd.first;
            last_d1_reg  <= cmd.last;
            fin_d1_reg   <= cmd.fin;
            last_d2_reg  <= last_d1_reg;
            fin_d2_reg   <= fin_d1_reg;
            done_reg     <= fin_d2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            prod_reg <= prod_next;
        end
        if (step_d1_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load)
        begin
            best_reg <= '0;
        end
        else if (last_d2_reg && sat > best_reg)
        begin
            best_reg <= sat;
        end
        if (cmd.out_load)
        begin
            peak_reg <= best_reg;
        end
    end

    assign status.done = done_reg;
    assign peak        = peak_reg;

endmodule

`default_nettype wire
